[rtl/core/wsp_pkg.sv]
// Shared types and constants for the WAV stream parser.
// Depends on nothing; every other file in rtl/core refers to it by scoped names.
package wsp_pkg;

  // Parser phases, one-hot.
  typedef enum logic [5:0] {
    PH_HEADER = 6'b000001,
    PH_CHUNK  = 6'b000010,
    PH_FMT    = 6'b000100,
    PH_SKIP   = 6'b001000,
    PH_DATA   = 6'b010000,
    PH_DONE   = 6'b100000
  } phase_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_SAMPLE     = 2'd0,
    ST_NOT_WAVE   = 2'd1,
    ST_DATA_EARLY = 2'd2,
    ST_BAD_FMT    = 2'd3
  } status_t;

  // Little-endian chunk tags as they build up in the shift register.
  localparam logic [31:0] TAG_WAVE = 32'h45564157;
  localparam logic [31:0] TAG_FMT  = 32'h20746D66;
  localparam logic [31:0] TAG_DATA = 32'h61746164;

  localparam logic [7:0] FLOAT_KIND  = 8'd3;
  localparam logic [7:0] PCM8_OFFSET = 8'h80;

  localparam int unsigned BPS_W = 13;

  typedef struct packed {
    phase_t             phase;
    logic [3:0]         byte_pos;
    logic [31:0]        tag;
    logic [31:0]        remaining;
    logic [4:0]         fmt_off;
    logic [7:0]         kind;
    logic [7:0]         chans;
    logic [31:0]        byte_rate;
    logic [15:0]        bits;
    logic [31:0]        shift;
    logic [BPS_W-1:0]   sbyte_cnt;
    logic [7:0]         chan;
  } parse_st_t;

  localparam parse_st_t PARSE_RESET = '{
    phase:     PH_HEADER,
    byte_pos:  4'd0,
    tag:       32'd0,
    remaining: 32'd0,
    fmt_off:   5'd0,
    kind:      8'd0,
    chans:     8'd0,
    byte_rate: 32'd0,
    bits:      16'd0,
    shift:     32'd0,
    sbyte_cnt: 13'd0,
    chan:      8'd0
  };

  typedef struct packed {
    logic signed [31:0] value;
    logic               is_float;
    logic [7:0]         channel;
    status_t            status;
    logic               last;
  } result_t;

endpackage

[rtl/core/wsp_sample_fmt.sv]
// Sample formatter: turns assembled little-endian sample bytes into Q1.31.
// Depends on wsp_pkg.
module wsp_sample_fmt (
  input  logic [31:0]               shift_word,
  input  logic [wsp_pkg::BPS_W-1:0] bps,
  input  logic                      is_float,
  output logic signed [31:0]        value
);

  // Float data passes raw; PCM is left-justified, 8-bit PCM is offset binary.
  always_comb begin
    priority if (is_float) begin
      value = $signed(shift_word);
    end else if (bps == 13'd1) begin
      value = $signed({shift_word[7:0] ^ wsp_pkg::PCM8_OFFSET, 24'd0});
    end else if (bps == 13'd2) begin
      value = $signed({shift_word[15:0], 16'd0});
    end else if (bps == 13'd3) begin
      value = $signed({shift_word[23:0], 8'd0});
    end else begin
      value = $signed(shift_word);
    end
  end

endmodule

[rtl/core/wsp_parse_core.sv]
// Parser state and next-state logic: header check, chunk walk, fmt latch, sample build.
// Depends on wsp_pkg and wsp_sample_fmt.
module wsp_parse_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                advance,
  input  logic [7:0]          byte_in,
  input  logic                start,
  output logic                res_valid,
  output wsp_pkg::result_t    res
);

  wsp_pkg::parse_st_t st_r, st_nxt, cur;

  logic [31:0]               tag_shift, rem_shift, rem_dec, shift_now;
  logic [wsp_pkg::BPS_W-1:0] bps, sbc_inc;
  logic [8:0]                chan_inc;
  logic                      fl;
  logic signed [31:0]        fmt_value;

  // A word flagged as file start is parsed against freshly reset state.
  assign cur       = start ? wsp_pkg::PARSE_RESET : st_r;
  assign tag_shift = {byte_in, cur.tag[31:8]};
  assign rem_shift = {byte_in, cur.remaining[31:8]};
  assign rem_dec   = cur.remaining - 32'd1;
  assign bps       = cur.bits[15:3];
  assign sbc_inc   = cur.sbyte_cnt + 13'd1;
  assign chan_inc  = {1'b0, cur.chan} + 9'd1;
  assign fl        = (cur.kind == wsp_pkg::FLOAT_KIND);
  assign shift_now = (cur.sbyte_cnt < 13'd4)
                   ? (cur.shift | ({24'd0, byte_in} << {cur.sbyte_cnt[1:0], 3'b000}))
                   : cur.shift;

  wsp_sample_fmt u_fmt (
    .shift_word (shift_now),
    .bps        (bps),
    .is_float   (fl),
    .value      (fmt_value)
  );

  always_comb begin
    st_nxt       = cur;
    res_valid    = 1'b0;
    res.value    = '0;
    res.is_float = 1'b0;
    res.channel  = '0;
    res.status   = wsp_pkg::ST_SAMPLE;
    res.last     = 1'b0;
    unique case (cur.phase)
      wsp_pkg::PH_HEADER: begin
        if (cur.byte_pos >= 4'd8) st_nxt.tag = tag_shift;
        if (cur.byte_pos >= 4'd11) begin
          if (tag_shift != wsp_pkg::TAG_WAVE) begin
            res_valid    = 1'b1;
            res.status   = wsp_pkg::ST_NOT_WAVE;
            st_nxt.phase = wsp_pkg::PH_DONE;
          end else begin
            st_nxt.phase    = wsp_pkg::PH_CHUNK;
            st_nxt.byte_pos = 4'd0;
          end
        end else begin
          st_nxt.byte_pos = cur.byte_pos + 4'd1;
        end
      end
      wsp_pkg::PH_CHUNK: begin
        if (cur.byte_pos < 4'd4) st_nxt.tag = tag_shift;
        else                     st_nxt.remaining = rem_shift;
        if (cur.byte_pos < 4'd7) begin
          st_nxt.byte_pos = cur.byte_pos + 4'd1;
        end else begin
          // Header complete: the tag finished four words ago, the size this word.
          st_nxt.byte_pos = 4'd0;
          if (cur.tag == wsp_pkg::TAG_FMT) begin
            st_nxt.fmt_off   = '0;
            st_nxt.kind      = '0;
            st_nxt.chans     = '0;
            st_nxt.byte_rate = '0;
            st_nxt.bits      = '0;
            st_nxt.phase     = (rem_shift == 32'd0) ? wsp_pkg::PH_CHUNK : wsp_pkg::PH_FMT;
          end else if (cur.tag == wsp_pkg::TAG_DATA) begin
            if (cur.byte_rate == 32'd0) begin
              res_valid    = 1'b1;
              res.status   = wsp_pkg::ST_DATA_EARLY;
              st_nxt.phase = wsp_pkg::PH_DONE;
            end else if (cur.chans == 8'd0 || bps == 13'd0) begin
              res_valid    = 1'b1;
              res.status   = wsp_pkg::ST_BAD_FMT;
              st_nxt.phase = wsp_pkg::PH_DONE;
            end else begin
              st_nxt.shift     = '0;
              st_nxt.sbyte_cnt = '0;
              st_nxt.chan      = '0;
              st_nxt.phase     = (rem_shift == 32'd0) ? wsp_pkg::PH_DONE : wsp_pkg::PH_DATA;
            end
          end else begin
            st_nxt.phase = (rem_shift == 32'd0) ? wsp_pkg::PH_CHUNK : wsp_pkg::PH_SKIP;
          end
        end
      end
      wsp_pkg::PH_FMT: begin
        if (cur.fmt_off == 5'd0) begin
          st_nxt.kind = byte_in;
        end else if (cur.fmt_off == 5'd2) begin
          st_nxt.chans = byte_in;
        end else if (cur.fmt_off >= 5'd8 && cur.fmt_off <= 5'd11) begin
          st_nxt.byte_rate = {byte_in, cur.byte_rate[31:8]};
        end else if (cur.fmt_off == 5'd14) begin
          st_nxt.bits[7:0] = byte_in;
        end else if (cur.fmt_off == 5'd15) begin
          st_nxt.bits[15:8] = byte_in;
        end
        if (cur.fmt_off < 5'd16) st_nxt.fmt_off = cur.fmt_off + 5'd1;
        st_nxt.remaining = rem_dec;
        if (rem_dec == 32'd0) begin
          st_nxt.phase    = wsp_pkg::PH_CHUNK;
          st_nxt.byte_pos = 4'd0;
        end
      end
      wsp_pkg::PH_SKIP: begin
        st_nxt.remaining = rem_dec;
        if (rem_dec == 32'd0) begin
          st_nxt.phase    = wsp_pkg::PH_CHUNK;
          st_nxt.byte_pos = 4'd0;
        end
      end
      wsp_pkg::PH_DATA: begin
        st_nxt.remaining = rem_dec;
        if (sbc_inc >= bps) begin
          // Whole sample; PCM wider than four bytes is dropped but still rotates.
          if (fl || bps <= 13'd4) begin
            res_valid    = 1'b1;
            res.value    = fmt_value;
            res.is_float = fl;
            res.channel  = cur.chan;
            res.last     = (rem_dec < {19'd0, bps});
          end
          st_nxt.chan      = (chan_inc >= {1'b0, cur.chans}) ? 8'd0 : chan_inc[7:0];
          st_nxt.sbyte_cnt = '0;
          st_nxt.shift     = '0;
        end else begin
          st_nxt.sbyte_cnt = sbc_inc;
          st_nxt.shift     = shift_now;
        end
        if (rem_dec == 32'd0) st_nxt.phase = wsp_pkg::PH_DONE;
      end
      wsp_pkg::PH_DONE: begin
      end
      default: begin
        st_nxt.phase = wsp_pkg::PH_DONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= wsp_pkg::PARSE_RESET;
    end else if (advance) begin
      st_r <= st_nxt;
    end
  end

endmodule

[rtl/core/wav_stream_parser_unit.sv]
// Top level of the WAV stream parser: input register, parser core, result register.
// Depends on wsp_pkg, wsp_parse_core and wsp_sample_fmt.
//
// This block parses a WAV (RIFF) file delivered one byte per input word and
// emits one output word per whole audio sample. Bytes 8 to 11 must spell WAVE;
// after that the chunks are walked by their little-endian 32-bit sizes with no
// pad byte. A fmt chunk latches the format byte, channel count, byte rate and
// bits per sample; a data chunk is cut into samples of bits/8 bytes, and each
// whole sample of 1 to 4 bytes leaves as a Q1.31 value (IEEE float data leaves
// as raw bits with the float flag set) together with a channel index that
// rotates over the channel count. The final whole sample of the data chunk
// carries out_tlast; a trailing partial sample is dropped. A file that is not
// WAVE, a data chunk before any fmt chunk, or a zero channel count or sample
// width produces a single word with a nonzero status and zero payload, after
// which the rest of the file is ignored, as are all bytes after the data
// chunk. Setting in_tuser on a byte restarts parsing with that byte as byte 0
// of a new file. The block takes one byte per clock cycle while the result
// register is empty or draining: the whole parse step for a byte sits between
// the input register and the result register, and a stalled result register
// holds at most one more byte in the input stage before in_tready drops.
module wav_stream_parser_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] in_byte
  input  logic        in_tuser,   // [0] file_start
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [31:0] sample_value, [39:32] channel_index
  output logic [2:0]  out_tuser,  // [0] is_float, [2:1] status
  output logic        out_tlast   // last_sample
);

  logic             s1_valid_r, s1_valid_nxt;
  logic [7:0]       s1_byte_r;
  logic             s1_start_r;
  logic             s1_adv, in_acc;
  logic             out_valid_r, out_valid_nxt;
  wsp_pkg::result_t out_res_r;
  logic             res_valid;
  wsp_pkg::result_t res;

  // The input stage moves on whenever the result register is empty or drains
  // this cycle, even for bytes that produce no result.
  assign s1_adv    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    if (in_acc) s1_valid_nxt = 1'b1;
    else if (s1_adv) s1_valid_nxt = 1'b0;
    else s1_valid_nxt = s1_valid_r;
  end

  always_comb begin
    if (s1_adv) out_valid_nxt = res_valid;
    else if (out_tready) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_byte_r  <= in_tdata;
      s1_start_r <= in_tuser;
    end
    if (s1_adv && res_valid) begin
      out_res_r <= res;
    end
  end

  wsp_parse_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (s1_adv),
    .byte_in   (s1_byte_r),
    .start     (s1_start_r),
    .res_valid (res_valid),
    .res       (res)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_res_r.channel, out_res_r.value};
  assign out_tuser  = {out_res_r.status, out_res_r.is_float};
  assign out_tlast  = out_res_r.last;

`ifndef ASSERT_OFF
  // Back pressure only reaches the input when both stages are full and stalled.
  a_ready_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (s1_valid_r && out_valid_r && !out_tready))
    else $error("in_tready low while the pipeline can still move");

  // Error words carry a zero payload.
  a_error_payload_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[2:1] != wsp_pkg::ST_SAMPLE) |->
      (out_tdata == 40'd0 && !out_tuser[0] && !out_tlast))
    else $error("error word with nonzero payload");

  // A byte that produces a result is written to the output the following cycle.
  a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && res_valid) |=> out_tvalid)
    else $error("result lost between core and output register");
`endif

endmodule
